[src/bpa_pkg.sv]
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared types and codes for the block pool allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bpa_pkg;

	// field widths
	localparam int IW     = 9;
	localparam int CMD_W  = 2;
	localparam int STAT_W = 2;

	// command codes on the input channel
	localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
	localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

	// result status codes
	typedef enum logic [STAT_W-1:0] {
		ST_OK        = 2'd0,
		ST_EXHAUSTED = 2'd1,
		ST_RANGE     = 2'd2,
		ST_NOT_USED  = 2'd3
	} status_t;

	// classified operation handed from front to back
	typedef enum logic [1:0] {
		OP_ALLOC  = 2'd0,
		OP_FREE   = 2'd1,
		OP_QUERY  = 2'd2,
		OP_REJECT = 2'd3
	} op_t;

	typedef struct packed {
		op_t           op;
		logic [IW-1:0] blk;
	} req_t;

	// front to queue
	typedef struct packed {
		logic push;
		req_t req;
	} qpush_t;

	// queue head to back
	typedef struct packed {
		logic valid;
		req_t req;
	} qhead_t;

endpackage

`default_nettype wire

[src/bpa_front.sv]
// ----------------------------------------------------------------------------
// bpa_front
// Accepts commands and classifies them against the current block count.
// ----------------------------------------------------------------------------
`default_nettype none

module bpa_front (
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic [bpa_pkg::CMD_W-1:0]   command,
	input  wire logic [bpa_pkg::IW-1:0]      block_index,
	input  wire logic [bpa_pkg::IW-1:0]      count,
	input  wire logic                        q_full,
	output bpa_pkg::qpush_t                  q_push
);

	logic in_range;

	// index must lie in 1..count
	assign in_range = (block_index != '0) && (block_index <= count);

	// stall while the queue has no room
	assign in_stall = q_full;

	// classify the command
	always_comb begin
		q_push.push    = in_valid && !q_full;
		q_push.req.blk = block_index;
		case (command)
			bpa_pkg::CMD_ALLOC: q_push.req.op = bpa_pkg::OP_ALLOC;
			bpa_pkg::CMD_FREE:  q_push.req.op = in_range ? bpa_pkg::OP_FREE : bpa_pkg::OP_REJECT;
			bpa_pkg::CMD_QUERY: q_push.req.op = in_range ? bpa_pkg::OP_QUERY : bpa_pkg::OP_REJECT;
			default:            q_push.req.op = bpa_pkg::OP_REJECT;
		endcase
	end

endmodule

`default_nettype wire

[src/bpa_queue.sv]
// ----------------------------------------------------------------------------
// bpa_queue
// Two-entry queue between the classifying front and the list back end.
// ----------------------------------------------------------------------------
`default_nettype none

module bpa_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire bpa_pkg::qpush_t q_push,
	output logic                 q_full,
	output bpa_pkg::qhead_t      q_head,
	input  wire logic            q_pop
);

	bpa_pkg::req_t entry_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    cnt_q;
	logic          do_push;
	logic          do_pop;

	assign q_full       = (cnt_q == 2'd2);
	assign q_head.valid = (cnt_q != 2'd0);
	assign q_head.req   = entry_q[rd_ptr_q];
	assign do_push      = q_push.push && !q_full;
	assign do_pop       = q_pop && q_head.valid;

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= q_push.req;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= ~wr_ptr_q;
			if (do_pop)  rd_ptr_q <= ~rd_ptr_q;
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

[src/bpa_back.sv]
// ----------------------------------------------------------------------------
// bpa_back
// Carries out allocate, free and query on the free and used link lists.
// ----------------------------------------------------------------------------
`default_nettype none

module bpa_back #(
	parameter int DEPTH = 256
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         init,
	input  wire logic [bpa_pkg::IW-1:0]       count,
	input  wire bpa_pkg::qhead_t              q_head,
	output logic                              q_pop,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic [bpa_pkg::STAT_W-1:0]        status,
	output logic [bpa_pkg::IW-1:0]            result_index,
	output logic [bpa_pkg::IW-1:0]            blocks_in_use
);

	localparam int IW = bpa_pkg::IW;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int RW = IW + 1;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_EXEC = 3'b010,
		S_LINK = 3'b100
	} state_t;

	function automatic logic [AW-1:0] addr_of(input logic [IW-1:0] b);
		logic [IW-1:0] d;
		d = b - IW'(1);
		return d[AW-1:0];
	endfunction

	// link memories, entries below the run start only
	logic [IW-1:0] next_mem [DEPTH];
	logic [IW-1:0] prev_mem [DEPTH];
	logic          used_mem [DEPTH];

	state_t           state_q, state_d;
	bpa_pkg::op_t     op_q;
	logic [IW-1:0]    blk_q;
	logic [IW-1:0]    free_head_q, free_head_d;
	logic [IW-1:0]    used_head_q, used_head_d;
	logic [IW-1:0]    total_q, total_d;
	logic [RW-1:0]    run_start_q, run_start_d;
	logic [IW-1:0]    next_rd_q, prev_rd_q;
	logic             used_rd_q;

	logic             out_valid_q;
	bpa_pkg::status_t status_q;
	logic [IW-1:0]    result_q, in_use_q;

	logic             rd_en;
	logic [AW-1:0]    rd_addr;
	logic             nxt_we, prv_we, use_we;
	logic [AW-1:0]    nxt_wa, prv_wa, use_wa;
	logic [IW-1:0]    nxt_wd, prv_wd;
	logic             use_wd;

	logic             exhausted;
	logic             out_free;
	logic             head_is_run;
	logic             blk_live;
	logic             load_out;
	bpa_pkg::status_t status_d;
	logic [IW-1:0]    result_d;

	assign exhausted   = (total_q >= count) || (free_head_q == '0) || (free_head_q > count);
	assign out_free    = !out_valid_q || !out_stall;
	assign head_is_run = ({1'b0, free_head_q} == run_start_q);
	assign blk_live    = ({1'b0, blk_q} < run_start_q) && used_rd_q;
	assign q_pop       = (state_q == S_IDLE) && q_head.valid;
	assign rd_en       = q_pop;
	assign rd_addr     = (q_head.req.op == bpa_pkg::OP_ALLOC) ? addr_of(free_head_q)
	                                                         : addr_of(q_head.req.blk);

	// sequencer and list updates
	always_comb begin
		state_d     = state_q;
		free_head_d = free_head_q;
		used_head_d = used_head_q;
		total_d     = total_q;
		run_start_d = run_start_q;
		nxt_we      = 1'b0;
		nxt_wa      = addr_of(blk_q);
		nxt_wd      = '0;
		prv_we      = 1'b0;
		prv_wa      = addr_of(free_head_q);
		prv_wd      = '0;
		use_we      = 1'b0;
		use_wa      = addr_of(free_head_q);
		use_wd      = 1'b0;
		load_out    = 1'b0;
		status_d    = bpa_pkg::ST_RANGE;
		result_d    = '0;
		case (state_q)
			S_IDLE: begin
				if (q_head.valid) begin
					state_d = S_EXEC;
					// mark the block taken and clear its back link up front
					if (q_head.req.op == bpa_pkg::OP_ALLOC && !exhausted) begin
						prv_we = 1'b1;
						prv_wa = addr_of(free_head_q);
						prv_wd = '0;
						use_we = 1'b1;
						use_wa = addr_of(free_head_q);
						use_wd = 1'b1;
					end
				end
			end
			S_EXEC: begin
				if (out_free) begin
					load_out = 1'b1;
					state_d  = S_IDLE;
					case (op_q)
						bpa_pkg::OP_ALLOC: begin
							if (exhausted) begin
								status_d = bpa_pkg::ST_EXHAUSTED;
							end else begin
								status_d    = bpa_pkg::ST_OK;
								result_d    = free_head_q;
								total_d     = total_q + IW'(1);
								// push onto the used list
								nxt_we      = 1'b1;
								nxt_wa      = addr_of(free_head_q);
								nxt_wd      = used_head_q;
								used_head_d = free_head_q;
								if (used_head_q != '0) begin
									prv_we = 1'b1;
									prv_wa = addr_of(used_head_q);
									prv_wd = free_head_q;
								end
								// pop the free head, splitting the run if it is one
								if (head_is_run) begin
									run_start_d = run_start_q + RW'(1);
									free_head_d = (free_head_q < count) ? free_head_q + IW'(1) : '0;
								end else begin
									free_head_d = next_rd_q;
								end
							end
						end
						bpa_pkg::OP_FREE: begin
							if (blk_live && total_q != '0) begin
								status_d = bpa_pkg::ST_OK;
								total_d  = total_q - IW'(1);
								state_d  = S_LINK;
								// unlink from the used list
								if (prev_rd_q != '0) begin
									nxt_we = 1'b1;
									nxt_wa = addr_of(prev_rd_q);
									nxt_wd = next_rd_q;
								end else begin
									used_head_d = next_rd_q;
								end
								if (next_rd_q != '0) begin
									prv_we = 1'b1;
									prv_wa = addr_of(next_rd_q);
									prv_wd = prev_rd_q;
								end
								use_we = 1'b1;
								use_wa = addr_of(blk_q);
								use_wd = 1'b0;
							end else begin
								status_d = bpa_pkg::ST_NOT_USED;
							end
						end
						bpa_pkg::OP_QUERY: begin
							status_d = blk_live ? bpa_pkg::ST_OK : bpa_pkg::ST_NOT_USED;
						end
						default: begin
							status_d = bpa_pkg::ST_RANGE;
						end
					endcase
				end
			end
			S_LINK: begin
				// push the freed block onto the free list
				nxt_we      = 1'b1;
				nxt_wa      = addr_of(blk_q);
				nxt_wd      = free_head_q;
				free_head_d = blk_q;
				state_d     = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// memories with registered reads
	always_ff @(posedge clk) begin
		if (nxt_we) next_mem[nxt_wa] <= nxt_wd;
		if (prv_we) prev_mem[prv_wa] <= prv_wd;
		if (use_we) used_mem[use_wa] <= use_wd;
		if (rd_en) begin
			next_rd_q <= next_mem[rd_addr];
			prev_rd_q <= prev_mem[rd_addr];
			used_rd_q <= used_mem[rd_addr];
		end
	end

	// item and result payload
	always_ff @(posedge clk) begin
		if (q_pop) begin
			op_q  <= q_head.req.op;
			blk_q <= q_head.req.blk;
		end
		if (load_out) begin
			status_q <= status_d;
			result_q <= result_d;
			in_use_q <= total_d;
		end
	end

	// control state and list heads
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			free_head_q <= IW'(1);
			used_head_q <= '0;
			total_q     <= '0;
			run_start_q <= RW'(1);
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (init) begin
				free_head_q <= IW'(1);
				used_head_q <= '0;
				total_q     <= '0;
				run_start_q <= RW'(1);
			end else begin
				free_head_q <= free_head_d;
				used_head_q <= used_head_d;
				total_q     <= total_d;
				run_start_q <= run_start_d;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign result_index  = result_q;
	assign blocks_in_use = in_use_q;

endmodule

`default_nettype wire

[src/block_pool_allocator.sv]
// result path: queue entry, S_IDLE and S_EXEC, then the result registers
// pacing: one command at a time, a successful free also passing S_LINK, set
//   by the read then write pass over the single-port link memories
// reset: the pool holds min(MAX_BLOCKS, 256) free blocks, used list empty;
//   a block count write rebuilds the pool with no clearing pass
// ----------------------------------------------------------------------------
// block_pool_allocator
// Fixed-size block pool with linked free and used lists, alloc/free/query.
// ----------------------------------------------------------------------------
`default_nettype none

module block_pool_allocator #(
	parameter int MAX_BLOCKS = 256
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [bpa_pkg::IW-1:0]        cfg_wdata,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [bpa_pkg::CMD_W-1:0]     command,
	input  wire logic [bpa_pkg::IW-1:0]        block_index,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [bpa_pkg::STAT_W-1:0]         status,
	output logic [bpa_pkg::IW-1:0]             result_index,
	output logic [bpa_pkg::IW-1:0]             blocks_in_use
);

	localparam int IW    = bpa_pkg::IW;
	localparam int DEPTH = (MAX_BLOCKS < 511) ? MAX_BLOCKS : 511;
	localparam logic [IW-1:0] CNT_MAX = IW'(DEPTH);
	localparam logic [IW-1:0] RST_CNT = IW'((MAX_BLOCKS < 256) ? MAX_BLOCKS : 256);

	logic [IW-1:0]   count_q;
	logic            init;
	logic            q_full;
	logic            q_pop;
	bpa_pkg::qpush_t q_push;
	bpa_pkg::qhead_t q_head;

	// a zero count write is ignored, larger counts saturate
	assign init = cfg_we && (cfg_wdata != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= RST_CNT;
		end else if (init) begin
			count_q <= (cfg_wdata > CNT_MAX) ? CNT_MAX : cfg_wdata;
		end
	end

	bpa_front u_front (
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.command     (command),
		.block_index (block_index),
		.count       (count_q),
		.q_full      (q_full),
		.q_push      (q_push)
	);

	bpa_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.q_push (q_push),
		.q_full (q_full),
		.q_head (q_head),
		.q_pop  (q_pop)
	);

	bpa_back #(
		.DEPTH (DEPTH)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.init          (init),
		.count         (count_q),
		.q_head        (q_head),
		.q_pop         (q_pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.result_index  (result_index),
		.blocks_in_use (blocks_in_use)
	);

endmodule

`default_nettype wire

[src/bpa_checker.sv]
// ----------------------------------------------------------------------------
// bpa_checker
// Port-level checks on the block pool allocator result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module bpa_checker (
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      out_valid,
	input wire logic                      out_stall,
	input wire logic [bpa_pkg::STAT_W-1:0] status,
	input wire logic [bpa_pkg::IW-1:0]    result_index,
	input wire logic [bpa_pkg::IW-1:0]    blocks_in_use
);

	// a stalled result stays offered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// only a successful allocate carries an index
	a_idx_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != bpa_pkg::ST_OK |-> result_index == '0)
		else $error("index on a failed result");

	// an allocated block counts as in use
	a_alloc_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_index != '0 |-> status == bpa_pkg::ST_OK && blocks_in_use != '0)
		else $error("allocation with bad status or count");

	// no result right out of reset
	a_reset: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !out_valid)
		else $error("result valid out of reset");

endmodule

bind block_pool_allocator bpa_checker u_bpa_checker (.*);

`default_nettype wire

[tb/block_pool_allocator_test.sv]
// ----------------------------------------------------------------------------
// block_pool_allocator_test
// Drives alloc, free and query commands into the block pool, predicts every
// status, index and in-use count with a behavioral pool, and compares the
// results in order. Runs several pool sizes and idle patterns on both sides.
// ----------------------------------------------------------------------------
`default_nettype none

module block_pool_allocator_test;

	localparam int MAXB   = 256;
	localparam int IW     = bpa_pkg::IW;
	localparam int CMD_W  = bpa_pkg::CMD_W;
	localparam int STAT_W = bpa_pkg::STAT_W;

	// command code with no operation behind it
	localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;

	typedef struct {
		logic [STAT_W-1:0] st;
		logic [IW-1:0]     idx;
		logic [IW-1:0]     used;
	} outcome_t;

	typedef struct {
		logic [CMD_W-1:0] cmd;
		logic [IW-1:0]    blk;
		bit               typed;
		outcome_t         want;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [IW-1:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [CMD_W-1:0] command = '0;
	logic [IW-1:0] block_index = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [STAT_W-1:0] status;
	logic [IW-1:0] result_index;
	logic [IW-1:0] blocks_in_use;

	block_pool_allocator #(.MAX_BLOCKS(MAXB)) i_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall), .command(command),
		.block_index(block_index), .out_valid(out_valid), .out_stall(out_stall),
		.status(status), .result_index(result_index), .blocks_in_use(blocks_in_use)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// shadow pool
	int unsigned pool_size;
	bit          flag_used [MAXB+1];
	int unsigned nxt [MAXB+1];
	int unsigned prv [MAXB+1];
	int unsigned run [MAXB+1];
	int unsigned f_head, f_tail, u_head, u_tail, n_used;

	outcome_t pending_results[$];
	int errors = 0;
	int sent = 0;
	int got = 0;
	int send_idle = 0;
	int recv_stall = 0;
	bit hold_off = 1'b0;

	function automatic bit in_pool(int unsigned b);
		return b >= 1 && b <= pool_size;
	endfunction

	function automatic void pool_rebuild(int unsigned count);
		pool_size = count;
		for (int i = 0; i <= MAXB; i++) begin
			flag_used[i] = 1'b0; nxt[i] = 0; prv[i] = 0; run[i] = 0;
		end
		run[1] = count;
		f_head = 1; f_tail = 1; u_head = 0; u_tail = 0; n_used = 0;
	endfunction

	function automatic outcome_t pool_apply(logic [CMD_W-1:0] cmd, int unsigned b);
		outcome_t o;
		int unsigned a, nh, nt, nx, p, n;
		o.st = bpa_pkg::ST_RANGE; o.idx = '0;
		if (cmd == bpa_pkg::CMD_ALLOC) begin
			if (n_used >= pool_size || !in_pool(f_head)) begin
				o.st = bpa_pkg::ST_EXHAUSTED;
			end else begin
				a = f_head; nh = f_head; nt = f_tail;
				nx = in_pool(a) ? nxt[a] : 0;
				// split one block off the untouched run
				if (run[a] > 1 && in_pool(a + 1)) begin
					nh = a + 1;
					run[nh] = run[a] - 1;
					prv[nh] = 0;
					nxt[nh] = nx;
					run[a] = 1;
					if (in_pool(nx)) prv[nx] = nh;
					else nt = nh;
				end else if (!in_pool(nx)) begin
					nh = 0; nt = 0;
				end else begin
					nh = nx;
					prv[nh] = 0;
				end
				f_head = nh; f_tail = nt;
				n_used++;
				prv[a] = 0;
				nxt[a] = u_head;
				flag_used[a] = 1'b1;
				if (in_pool(u_head)) prv[u_head] = a;
				else u_tail = a;
				u_head = a;
				o.st = bpa_pkg::ST_OK; o.idx = IW'(a);
			end
		end else if (cmd == bpa_pkg::CMD_FREE) begin
			if (!in_pool(b)) begin
				o.st = bpa_pkg::ST_RANGE;
			end else if (!flag_used[b] || n_used == 0) begin
				o.st = bpa_pkg::ST_NOT_USED;
			end else begin
				// unlink from used list, push on free list
				p = prv[b]; n = nxt[b];
				if (in_pool(p)) nxt[p] = n; else u_head = n;
				if (in_pool(n)) prv[n] = p; else u_tail = p;
				n_used--;
				flag_used[b] = 1'b0;
				run[b] = 1; prv[b] = 0; nxt[b] = f_head;
				if (in_pool(f_head)) prv[f_head] = b;
				else f_tail = b;
				f_head = b;
				o.st = bpa_pkg::ST_OK;
			end
		end else if (cmd == bpa_pkg::CMD_QUERY) begin
			if (!in_pool(b)) o.st = bpa_pkg::ST_RANGE;
			else o.st = flag_used[b] ? bpa_pkg::ST_OK : bpa_pkg::ST_NOT_USED;
		end
		o.used = IW'(n_used);
		return o;
	endfunction

	// result checker
	always @(posedge clk) begin
		outcome_t w;
		if (arst_n && out_valid && !out_stall) begin
			got++;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result st=%0d idx=%0d used=%0d", $time,
					status, result_index, blocks_in_use);
				errors++;
			end else begin
				w = pending_results.pop_front();
				if (status !== w.st) begin
					$display("%0t: status expected %0d actual %0d", $time, w.st, status);
					errors++;
				end
				if (result_index !== w.idx) begin
					$display("%0t: result_index expected %0d actual %0d", $time,
						w.idx, result_index);
					errors++;
				end
				if (blocks_in_use !== w.used) begin
					$display("%0t: blocks_in_use expected %0d actual %0d", $time,
						w.used, blocks_in_use);
					errors++;
				end
			end
		end
	end

	// receiver stall pattern, with a long hold-off on request
	always @(negedge clk) begin
		if (hold_off) out_stall <= 1'b1;
		else out_stall <= ($urandom_range(99) < recv_stall);
	end

	task automatic send(logic [CMD_W-1:0] cmd, logic [IW-1:0] blk, bit typed, outcome_t want);
		outcome_t o;
		while (send_idle > 0 && $urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		block_index <= blk;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		o = pool_apply(cmd, blk);
		if (typed && (o.st !== want.st || o.idx !== want.idx || o.used !== want.used)) begin
			$display("%0t: table row cmd=%0d blk=%0d expected %0d/%0d/%0d shadow %0d/%0d/%0d",
				$time, cmd, blk, want.st, want.idx, want.used, o.st, o.idx, o.used);
			errors++;
		end
		pending_results.push_back(typed ? want : o);
		sent++;
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_count(logic [IW-1:0] v);
		int unsigned c;
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		c = {23'd0, v};
		if (c != 0) pool_rebuild(c > MAXB ? MAXB : c);
		@(negedge clk);
	endtask

	// random item biased toward in-range blocks
	task automatic random_item();
		logic [CMD_W-1:0] cmd;
		logic [IW-1:0] blk;
		outcome_t none;
		int r;
		none = '{default: '0};
		r = $urandom_range(99);
		if (r < 40) cmd = bpa_pkg::CMD_ALLOC;
		else if (r < 75) cmd = bpa_pkg::CMD_FREE;
		else if (r < 96) cmd = bpa_pkg::CMD_QUERY;
		else cmd = CMD_UNKNOWN;
		r = $urandom_range(99);
		if (r < 70) blk = IW'($urandom_range(pool_size, 1));
		else if (r < 80) blk = '0;
		else blk = IW'($urandom_range(511));
		send(cmd, blk, 1'b0, none);
	endtask

	row_t dir_rows[$];

	function automatic row_t mk(logic [CMD_W-1:0] c, logic [IW-1:0] b, bit t,
			logic [STAT_W-1:0] s, logic [IW-1:0] i, logic [IW-1:0] u);
		row_t r;
		r.cmd = c; r.blk = b; r.typed = t;
		r.want.st = s; r.want.idx = i; r.want.used = u;
		return r;
	endfunction

	initial begin
		#20000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		int counts[6];
		int idles[4][2];
		counts = '{2, 5, 1, 256, 37, 300};
		idles = '{'{0, 0}, '{54, 0}, '{0, 54}, '{34, 34}};
		pool_rebuild(MAXB);
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed table on the reset pool of 256
		dir_rows.push_back(mk(bpa_pkg::CMD_QUERY, 1, 1, bpa_pkg::ST_NOT_USED, 0, 0));
		dir_rows.push_back(mk(bpa_pkg::CMD_FREE, 1, 1, bpa_pkg::ST_NOT_USED, 0, 0));
		dir_rows.push_back(mk(bpa_pkg::CMD_FREE, 0, 1, bpa_pkg::ST_RANGE, 0, 0));
		dir_rows.push_back(mk(bpa_pkg::CMD_QUERY, 0, 1, bpa_pkg::ST_RANGE, 0, 0));
		dir_rows.push_back(mk(bpa_pkg::CMD_QUERY, 257, 1, bpa_pkg::ST_RANGE, 0, 0));
		dir_rows.push_back(mk(bpa_pkg::CMD_FREE, 511, 1, bpa_pkg::ST_RANGE, 0, 0));
		dir_rows.push_back(mk(CMD_UNKNOWN, 1, 1, bpa_pkg::ST_RANGE, 0, 0));
		dir_rows.push_back(mk(bpa_pkg::CMD_ALLOC, 0, 1, bpa_pkg::ST_OK, 1, 1));
		dir_rows.push_back(mk(bpa_pkg::CMD_ALLOC, 511, 1, bpa_pkg::ST_OK, 2, 2));
		dir_rows.push_back(mk(bpa_pkg::CMD_QUERY, 2, 1, bpa_pkg::ST_OK, 0, 2));
		dir_rows.push_back(mk(bpa_pkg::CMD_FREE, 1, 1, bpa_pkg::ST_OK, 0, 1));
		dir_rows.push_back(mk(bpa_pkg::CMD_FREE, 1, 1, bpa_pkg::ST_NOT_USED, 0, 1));
		dir_rows.push_back(mk(bpa_pkg::CMD_ALLOC, 0, 1, bpa_pkg::ST_OK, 1, 2));
		dir_rows.push_back(mk(bpa_pkg::CMD_ALLOC, 0, 1, bpa_pkg::ST_OK, 3, 3));
		dir_rows.push_back(mk(bpa_pkg::CMD_FREE, 3, 0, bpa_pkg::ST_OK, 0, 0));
		dir_rows.push_back(mk(bpa_pkg::CMD_FREE, 2, 0, bpa_pkg::ST_OK, 0, 0));
		dir_rows.push_back(mk(bpa_pkg::CMD_QUERY, 256, 0, bpa_pkg::ST_OK, 0, 0));
		dir_rows.push_back(mk(bpa_pkg::CMD_ALLOC, 0, 0, bpa_pkg::ST_OK, 0, 0));
		foreach (dir_rows[k]) send(dir_rows[k].cmd, dir_rows[k].blk, dir_rows[k].typed,
			dir_rows[k].want);
		drain();

		// zero write is ignored: pool state carries on
		write_count('0);
		send(bpa_pkg::CMD_QUERY, 1, 1'b0, dir_rows[0].want);
		drain();

		// exhaust a pool of one
		write_count(IW'(1));
		send(bpa_pkg::CMD_ALLOC, 0, 1'b1, '{bpa_pkg::ST_OK, 1, 1});
		send(bpa_pkg::CMD_ALLOC, 0, 1'b1, '{bpa_pkg::ST_EXHAUSTED, 0, 1});
		send(bpa_pkg::CMD_QUERY, 2, 1'b1, '{bpa_pkg::ST_RANGE, 0, 1});
		drain();

		// random phases across pool sizes and idle patterns
		for (int ph = 0; ph < 24; ph++) begin
			write_count(IW'(counts[ph % 6]));
			send_idle = idles[ph % 4][0];
			recv_stall = idles[ph % 4][1];
			if (ph == 5) begin
				// long receiver hold-off while the sender keeps offering
				fork
					begin
						hold_off = 1'b1;
						repeat (60) @(negedge clk);
						hold_off = 1'b0;
					end
					for (int k = 0; k < 35; k++) random_item();
				join
			end else begin
				for (int k = 0; k < 35; k++) random_item();
			end
			// sender pauses until every result is back
			drain();
		end
		send_idle = 0;
		recv_stall = 0;
		drain();

		$display("Covered %0d commands, %0d results, pool sizes 1 to 256 with stalls.",
			sent, got);
		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

`default_nettype wire

[sim.f]
src/bpa_pkg.sv
src/bpa_front.sv
src/bpa_queue.sv
src/bpa_back.sv
src/block_pool_allocator.sv
src/bpa_checker.sv
tb/block_pool_allocator_test.sv
